// ----- rtl/aprt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, field widths and codes of the access policy rule table.
// No dependencies; aprt_if, aprt_rule_check and the top level import this package.
package aprt_pkg;

   localparam int MAX_RULES_DEF = 16;

   localparam int OPERATION_W    = 3;
   localparam int ID_W           = 32;
   localparam int OP_MASK_W      = 16;
   localparam int SIZE_W         = 32;
   localparam int MODE_W         = 2;
   localparam int LIMIT_SLOT_W   = 4;
   localparam int DECISION_W     = 2;
   localparam int RULE_INDEX_W   = 8;
   localparam int RULE_TOTAL_W   = 9;
   localparam int COUNTER_W      = 32;

   localparam logic [OPERATION_W-1:0] OP_EVALUATE  = 3'd0;
   localparam logic [OPERATION_W-1:0] OP_ADD_RULE  = 3'd1;
   localparam logic [OPERATION_W-1:0] OP_SET_MODE  = 3'd2;
   localparam logic [OPERATION_W-1:0] OP_SET_LIMIT = 3'd3;
   localparam logic [OPERATION_W-1:0] OP_ENABLE    = 3'd4;
   localparam logic [OPERATION_W-1:0] OP_DISABLE   = 3'd5;

   localparam logic [MODE_W-1:0] MODE_WARN  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BLOCK = 2'd2;

   localparam logic [DECISION_W-1:0] VERDICT_ALLOW = 2'd0;
   localparam logic [DECISION_W-1:0] VERDICT_WARN  = 2'd1;
   localparam logic [DECISION_W-1:0] VERDICT_DENY  = 2'd2;

   localparam logic [LIMIT_SLOT_W-1:0] SLOT_COUNT = 4'd8;
   localparam logic [LIMIT_SLOT_W-1:0] SLOT_STORED = 4'd0;

   typedef struct packed {
      logic [OPERATION_W-1:0]  operation;
      logic [ID_W-1:0]         requester_id;
      logic [OP_MASK_W-1:0]    op_mask;
      logic [SIZE_W-1:0]       request_size;
      logic [SIZE_W-1:0]       limit_value;
      logic [MODE_W-1:0]       mode_value;
      logic [LIMIT_SLOT_W-1:0] limit_slot;
   } req_type;

   typedef struct packed {
      logic                    ok;
      logic [DECISION_W-1:0]   decision;
      logic [RULE_INDEX_W-1:0] rule_index;
      logic [RULE_TOTAL_W-1:0] rule_total;
      logic [COUNTER_W-1:0]    eval_total;
      logic [COUNTER_W-1:0]    violation_total;
      logic [COUNTER_W-1:0]    warning_total;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]      rule_id;
      logic [OP_MASK_W-1:0] allow_mask;
      logic [SIZE_W-1:0]    size_limit;
      logic [MODE_W-1:0]    mode;
      logic                 active;
   } rule_type;

   typedef struct packed {
      logic                  id_hit;
      logic                  decides;
      logic                  violation;
      logic                  warning;
      logic [DECISION_W-1:0] decision;
   } check_type;

endpackage

// ----- rtl/aprt_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response beats.
// Depends on aprt_pkg for the payload types.
interface aprt_req_if;
   import aprt_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface aprt_rsp_if;
   import aprt_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/aprt_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module aprt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/aprt_rule_check.sv -----
`timescale 1ns / 1ps
// Shared compare unit: checks one stored rule against the current request.
// Depends on aprt_pkg for the rule, request and check result types.
module aprt_rule_check (
   input  aprt_pkg::rule_type  rule,
   input  aprt_pkg::req_type   req,
   output aprt_pkg::check_type check
);
   import aprt_pkg::*;

   logic                 match;
   logic                 outside;
   logic                 inside_hit;
   logic                 over_limit;

   always_comb begin
      match      = (rule.rule_id == req.requester_id) && rule.active;
      outside    = |(req.op_mask & ~rule.allow_mask);
      inside_hit = |(req.op_mask & rule.allow_mask);
      over_limit = req.request_size > rule.size_limit;

      check.id_hit    = rule.rule_id == req.requester_id;
      check.decides   = match && (outside || inside_hit);
      check.violation = outside || over_limit;
      check.warning   = outside && (rule.mode == MODE_WARN);
      check.decision  = VERDICT_ALLOW;
      if (outside) begin
         if (rule.mode == MODE_BLOCK) begin
            check.decision = VERDICT_DENY;
         end else if (rule.mode == MODE_WARN) begin
            check.decision = VERDICT_WARN;
         end
      end else if (over_limit && (rule.mode == MODE_BLOCK)) begin
         check.decision = VERDICT_DENY;
      end
   end

endmodule

// ----- rtl/access_policy_rule_table.sv -----
`timescale 1ns / 1ps
// Top level of the access policy rule table: sequencer, counters and rule RAM.
// Depends on aprt_pkg, aprt_if, aprt_ram and aprt_rule_check.
//
//   Channel   Dir   Handshake     Beat carries
//   req_port  in    valid/ready   operation, id, mask, size, limit, mode, slot
//   rsp_port  out   valid/ready   ok, decision, index, rule and counter totals
//
// Add rule, unknown operations, bad slots and an empty table present the
// response in the cycle after acceptance. Evaluate and update by id scan one
// rule per cycle through the single read port of the rule RAM and stop at the
// first deciding or id-matching rule or after the last stored rule.
// The request side is ready only when no beat is in progress; a stalled
// response holds until taken. Reset clears the rule count and all counters.
module access_policy_rule_table #(
   parameter int MAX_RULES = aprt_pkg::MAX_RULES_DEF
) (
   input logic          clock,
   input logic          reset,
   aprt_req_if.sink     req_port,
   aprt_rsp_if.source   rsp_port
);
   import aprt_pkg::*;

   localparam int IDX_W  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CNT_W  = $clog2(MAX_RULES + 1);
   localparam int RULE_W = $bits(rule_type);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [COUNTER_W-1:0]    eval_ff, eval_in;
   logic [COUNTER_W-1:0]    viol_ff, viol_in;
   logic [COUNTER_W-1:0]    warn_ff, warn_in;
   logic                    ok_ff, ok_in;
   logic [DECISION_W-1:0]   dec_ff, dec_in;
   logic [RULE_INDEX_W-1:0] index_ff, index_in;

   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr;
   rule_type                ram_wdata;
   logic [IDX_W-1:0]        ram_raddr;
   logic [RULE_W-1:0]       ram_rdata;
   rule_type                entry;
   check_type               chk;
   logic                    last;

   assign entry = rule_type'(ram_rdata);

   aprt_ram #(
      .WIDTH (RULE_W),
      .DEPTH (MAX_RULES)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   aprt_rule_check u_check (
      .rule  (entry),
      .req   (req_ff),
      .check (chk)
   );

   assign last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      eval_in   = eval_ff;
      viol_in   = viol_ff;
      warn_in   = warn_ff;
      ok_in     = ok_ff;
      dec_in    = dec_ff;
      index_in  = index_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = entry;
      ram_raddr = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               req_in   = req_port.data;
               idx_in   = '0;
               ok_in    = 1'b0;
               dec_in   = VERDICT_ALLOW;
               index_in = '0;
               state_in = ST_RESP;
               case (req_port.data.operation)
                  OP_EVALUATE: begin
                     eval_in = eval_ff + COUNTER_W'(1);
                     if (count_ff == '0) begin
                        ok_in   = 1'b1;
                        dec_in  = VERDICT_DENY;
                        viol_in = viol_ff + COUNTER_W'(1);
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_ADD_RULE: begin
                     if (count_ff < CNT_W'(MAX_RULES)) begin
                        ram_we               = 1'b1;
                        ram_waddr            = count_ff[IDX_W-1:0];
                        ram_wdata.rule_id    = req_port.data.requester_id;
                        ram_wdata.allow_mask = req_port.data.op_mask;
                        ram_wdata.size_limit = req_port.data.limit_value;
                        ram_wdata.mode       = req_port.data.mode_value;
                        ram_wdata.active     = 1'b1;
                        index_in             = RULE_INDEX_W'(count_ff[IDX_W-1:0]);
                        count_in             = count_ff + CNT_W'(1);
                        ok_in                = 1'b1;
                     end
                  end
                  OP_SET_MODE, OP_ENABLE, OP_DISABLE: begin
                     if (count_ff != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_SET_LIMIT: begin
                     if ((req_port.data.limit_slot < SLOT_COUNT) && (count_ff != '0)) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            ram_raddr = idx_ff + IDX_W'(1);
            if (req_ff.operation == OP_EVALUATE) begin
               if (chk.decides) begin
                  ok_in    = 1'b1;
                  dec_in   = chk.decision;
                  viol_in  = viol_ff + COUNTER_W'(chk.violation);
                  warn_in  = warn_ff + COUNTER_W'(chk.warning);
                  state_in = ST_RESP;
               end else if (last) begin
                  ok_in    = 1'b1;
                  dec_in   = VERDICT_DENY;
                  viol_in  = viol_ff + COUNTER_W'(1);
                  state_in = ST_RESP;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               if (chk.id_hit) begin
                  ok_in    = 1'b1;
                  ram_we   = 1'b1;
                  state_in = ST_RESP;
                  case (req_ff.operation)
                     OP_SET_MODE: ram_wdata.mode = req_ff.mode_value;
                     OP_SET_LIMIT: begin
                        if (req_ff.limit_slot == SLOT_STORED) begin
                           ram_wdata.size_limit = req_ff.limit_value;
                        end
                     end
                     OP_ENABLE: ram_wdata.active = 1'b1;
                     OP_DISABLE: ram_wdata.active = 1'b0;
                     default: begin
                     end
                  endcase
               end else if (last) begin
                  state_in = ST_RESP;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_RESP: begin
            if (rsp_port.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         eval_ff  <= '0;
         viol_ff  <= '0;
         warn_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         eval_ff  <= eval_in;
         viol_ff  <= viol_in;
         warn_ff  <= warn_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      idx_ff   <= idx_in;
      ok_ff    <= ok_in;
      dec_ff   <= dec_in;
      index_ff <= index_in;
   end

   assign req_port.ready = (state_ff == ST_IDLE);
   assign rsp_port.valid = (state_ff == ST_RESP);

   always_comb begin
      rsp_port.data.ok              = ok_ff;
      rsp_port.data.decision        = dec_ff;
      rsp_port.data.rule_index      = index_ff;
      rsp_port.data.rule_total      = RULE_TOTAL_W'(count_ff);
      rsp_port.data.eval_total      = eval_ff;
      rsp_port.data.violation_total = viol_ff;
      rsp_port.data.warning_total   = warn_ff;
   end

endmodule
